// ===== rtl/core/wma_pkg.sv =====
// Shared types, constants and helpers of the weighted moving average filter.
// No dependencies; every other file but wma_ram imports this package.
package wma_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned WeightW = 8;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW   = SampleW + WeightW + 1;
  localparam int unsigned RegTaps = 12;
  localparam int unsigned LowTaps = 6;

  localparam logic [CfgW-1:0]    WeightsLowRst  = 48'h0605_0403_0201;
  localparam logic [CfgW-1:0]    WeightsHighRst = 48'h0C0B_0A09_0807;
  localparam logic [WeightW-1:0] WeightTotalRst = 8'd78;

  localparam logic [SampleW-1:0] AvgMax = 16'h7FFF;
  localparam logic [SampleW-1:0] AvgMin = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWeightsLow  = 2'd0,
    CfgWeightsHigh = 2'd1,
    CfgWeightTotal = 2'd2
  } cfg_idx_e;

  function automatic logic [WeightW-1:0] tap_weight(logic [CfgW-1:0] lo, logic [CfgW-1:0] hi,
                                                    int unsigned tap);
    logic [WeightW-1:0] w;
    w = '0;
    if (tap < LowTaps) begin
      w = lo[WeightW*tap +: WeightW];
    end else if (tap < RegTaps) begin
      w = hi[WeightW*(tap-LowTaps) +: WeightW];
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/wma_sample_if.sv =====
// Input channel of the filter: one signed sample per item.
// Depends on wma_pkg.
interface wma_sample_if
  import wma_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/wma_result_if.sv =====
// Output channel of the filter: saturated average and clip flag per item.
// Depends on wma_pkg.
interface wma_result_if
  import wma_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] average;
  logic                      clipped;

  modport source (output valid, output average, output clipped, input ready);
  modport sink (input valid, input average, input clipped, output ready);
endinterface

// ===== rtl/core/wma_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wma_mac.sv =====
// Sample window in a circular RAM and the multiply-accumulate sequencer over it.
// Depends on wma_pkg and wma_ram.
module wma_mac
  import wma_pkg::*;
#(
  parameter int unsigned TAPS = 12,
  parameter int unsigned AccW = 29
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [CfgW-1:0]           weights_low_i,
  input  logic [CfgW-1:0]           weights_high_i,
  output logic                      idle_o,
  output logic                      acc_vld_o,
  input  logic                      acc_rdy_i,
  output logic signed [AccW-1:0]    acc_o
);

  localparam int unsigned TapW = $clog2(TAPS);
  localparam int unsigned CntW = $clog2(TAPS + 1);

  typedef enum logic [2:0] {
    MacIdle = 3'b001,
    MacRun  = 3'b010,
    MacDone = 3'b100
  } mac_state_e;

  mac_state_e                state_q, state_d;
  logic [TapW-1:0]           wptr_q, wptr_d;
  logic [TapW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           iss_cnt_q, iss_cnt_d;
  logic [TAPS-1:0]           valid_q, valid_d;
  logic                      s1_vld_q, s1_vld_d;
  logic                      s1_last_q, s1_last_d;
  logic                      s1_ok_q, s1_ok_d;
  logic [WeightW-1:0]        s1_w_q, s1_w_d;
  logic                      s2_vld_q, s2_vld_d;
  logic                      s2_last_q, s2_last_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic                      issue;
  logic [SampleW-1:0]        rdata;
  logic signed [SampleW-1:0] op;
  logic signed [WeightW:0]   wop;

  function automatic logic [TapW-1:0] inc_ptr(logic [TapW-1:0] p);
    logic [TapW-1:0] n;
    n = (p == TapW'(TAPS - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  wma_ram #(
    .Width(SampleW),
    .Depth(TAPS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (start_i),
    .waddr_i(wptr_q),
    .wdata_i(sample_i),
    .re_i   (issue),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  assign issue = (state_q == MacRun) && (iss_cnt_q < CntW'(TAPS));

  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    rd_ptr_d  = rd_ptr_q;
    iss_cnt_d = iss_cnt_q;
    valid_d   = valid_q;
    acc_d     = acc_q;
    case (state_q)
      MacIdle: begin
        if (start_i) begin
          valid_d[wptr_q] = 1'b1;
          wptr_d          = inc_ptr(wptr_q);
          rd_ptr_d        = inc_ptr(wptr_q);
          iss_cnt_d       = '0;
          acc_d           = '0;
          state_d         = MacRun;
        end
      end
      MacRun: begin
        if (issue) begin
          rd_ptr_d  = inc_ptr(rd_ptr_q);
          iss_cnt_d = iss_cnt_q + 1'b1;
        end
        if (s2_vld_q) begin
          acc_d = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
          if (s2_last_q) begin
            state_d = MacDone;
          end
        end
      end
      MacDone: begin
        if (acc_rdy_i) begin
          state_d = MacIdle;
        end
      end
      default: begin
        state_d = MacIdle;
      end
    endcase
  end

  always_comb begin
    s1_vld_d  = issue;
    s1_last_d = issue && (iss_cnt_q == CntW'(TAPS - 1));
    s1_ok_d   = valid_q[rd_ptr_q];
    s1_w_d    = tap_weight(weights_low_i, weights_high_i, int'(iss_cnt_q));
    s2_vld_d  = s1_vld_q;
    s2_last_d = s1_last_q;
    op        = s1_ok_q ? $signed(rdata) : '0;
    wop       = $signed({1'b0, s1_w_q});
    prod_d    = op * wop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= MacIdle;
      wptr_q    <= '0;
      rd_ptr_q  <= '0;
      iss_cnt_q <= '0;
      valid_q   <= '0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wptr_q    <= wptr_d;
      rd_ptr_q  <= rd_ptr_d;
      iss_cnt_q <= iss_cnt_d;
      valid_q   <= valid_d;
      s1_vld_q  <= s1_vld_d;
      s1_last_q <= s1_last_d;
      s2_vld_q  <= s2_vld_d;
      s2_last_q <= s2_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q <= s1_ok_d;
    s1_w_q  <= s1_w_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
  end

  assign idle_o    = (state_q == MacIdle);
  assign acc_vld_o = (state_q == MacDone);
  assign acc_o     = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MacIdle) |-> (!s1_vld_q && !s2_vld_q))
    else $error("mac pipeline busy while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_cnt_q <= CntW'(TAPS))
    else $error("mac tap counter past window depth");

endmodule

// ===== rtl/core/wma_div.sv =====
// Radix-2 restoring divider, saturation and output register of the filter.
// Depends on wma_pkg and wma_result_if.
module wma_div
  import wma_pkg::*;
#(
  parameter int unsigned AccW = 29
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_vld_i,
  output logic                   acc_rdy_o,
  input  logic signed [AccW-1:0] acc_i,
  input  logic [WeightW-1:0]     total_i,
  wma_result_if.source           out_o
);

  localparam int unsigned CntW = $clog2(AccW + 1);

  typedef enum logic [2:0] {
    DivIdle = 3'b001,
    DivRun  = 3'b010,
    DivDone = 3'b100
  } div_state_e;

  div_state_e         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [WeightW-1:0] rem_q, rem_d;
  logic [AccW-1:0]    quo_q, quo_d;
  logic               neg_q, neg_d;
  logic [WeightW-1:0] div_q, div_d;
  logic               out_vld_q, out_vld_d;
  logic [SampleW-1:0] out_avg_q, out_avg_d;
  logic               out_clip_q, out_clip_d;
  logic [WeightW:0]   trial;
  logic [WeightW:0]   diff;
  logic               ge;
  logic               clip;
  logic [SampleW-1:0] avg;

  assign trial = {rem_q, quo_q[AccW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    if (neg_q) begin
      clip = (|quo_q[AccW-1:SampleW]) || (quo_q[SampleW-1] && (|quo_q[SampleW-2:0]));
    end else begin
      clip = |quo_q[AccW-1:SampleW-1];
    end
    if (clip) begin
      avg = neg_q ? AvgMin : AvgMax;
    end else begin
      avg = neg_q ? (~quo_q[SampleW-1:0] + 1'b1) : quo_q[SampleW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    neg_d      = neg_q;
    div_d      = div_q;
    out_vld_d  = out_vld_q;
    out_avg_d  = out_avg_q;
    out_clip_d = out_clip_q;
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      DivIdle: begin
        if (acc_vld_i) begin
          neg_d   = acc_i[AccW-1];
          quo_d   = acc_i[AccW-1] ? (~acc_i + 1'b1) : acc_i;
          rem_d   = '0;
          div_d   = (total_i == '0) ? WeightW'(1) : total_i;
          cnt_d   = '0;
          state_d = DivRun;
        end
      end
      DivRun: begin
        rem_d = ge ? diff[WeightW-1:0] : trial[WeightW-1:0];
        quo_d = {quo_q[AccW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(AccW - 1)) begin
          state_d = DivDone;
        end
      end
      DivDone: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_avg_d  = avg;
          out_clip_d = clip;
          state_d    = DivIdle;
        end
      end
      default: begin
        state_d = DivIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= DivIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    neg_q      <= neg_d;
    div_q      <= div_d;
    out_avg_q  <= out_avg_d;
    out_clip_q <= out_clip_d;
  end

  assign acc_rdy_o     = (state_q == DivIdle);
  assign out_o.valid   = out_vld_q;
  assign out_o.average = out_avg_q;
  assign out_o.clipped = out_clip_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DivRun) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DivDone) |-> (cnt_q == CntW'(AccW)))
    else $error("divider finished after wrong step count");

endmodule

// ===== rtl/core/weighted_moving_average_filter.sv =====
// Top level of the weighted moving average filter: configuration registers,
// window/MAC stage and divider stage. Depends on wma_pkg, both interfaces,
// wma_mac and wma_div.
//
// Usage: samples enter on in_i (valid/ready), one signed 16-bit sample per
// item; each item yields one item on out_o carrying the weighted average of
// the last TAPS samples and a clip flag. Weights and the divisor are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only while
// the block is idle, and the block itself does not enforce this.
// The accumulator width is AccW = 25 + clog2(TAPS). The window RAM is read
// one tap per cycle, then the quotient is formed one bit per cycle. The MAC
// and divider overlap: the MAC stage can take the next sample while the
// divider is still working on the last sum.
// Reset clears the window to zeros and loads the default weights 1..12 with
// divisor 78. When out_o stalls, the result holds in the output register, the
// divider holds the next result, the MAC stage holds the sum after that, and
// in_i.ready stays low while the MAC stage is busy or holds a sum.
module weighted_moving_average_filter
  import wma_pkg::*;
#(
  parameter int unsigned TAPS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wma_sample_if.sink         in_i,
  wma_result_if.source       out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned AccW = ProdW + $clog2(TAPS);

  logic [CfgW-1:0]        weights_low_q, weights_low_d;
  logic [CfgW-1:0]        weights_high_q, weights_high_d;
  logic [WeightW-1:0]     weight_total_q, weight_total_d;
  logic                   mac_idle;
  logic                   start;
  logic                   acc_vld;
  logic                   acc_rdy;
  logic signed [AccW-1:0] acc;

  always_comb begin
    weights_low_d  = weights_low_q;
    weights_high_d = weights_high_q;
    weight_total_d = weight_total_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWeightsLow:  weights_low_d  = cfg_wdata_i;
        CfgWeightsHigh: weights_high_d = cfg_wdata_i;
        CfgWeightTotal: weight_total_d = cfg_wdata_i[WeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_low_q  <= WeightsLowRst;
      weights_high_q <= WeightsHighRst;
      weight_total_q <= WeightTotalRst;
    end else begin
      weights_low_q  <= weights_low_d;
      weights_high_q <= weights_high_d;
      weight_total_q <= weight_total_d;
    end
  end

  assign in_i.ready = mac_idle;
  assign start      = in_i.valid && mac_idle;

  wma_mac #(
    .TAPS(TAPS),
    .AccW(AccW)
  ) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .sample_i      (in_i.sample),
    .weights_low_i (weights_low_q),
    .weights_high_i(weights_high_q),
    .idle_o        (mac_idle),
    .acc_vld_o     (acc_vld),
    .acc_rdy_i     (acc_rdy),
    .acc_o         (acc)
  );

  wma_div #(
    .AccW(AccW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_vld_i(acc_vld),
    .acc_rdy_o(acc_rdy),
    .acc_i    (acc),
    .total_i  (weight_total_q),
    .out_o    (out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken while window pass in progress");

endmodule
